/* design/vma_pkg.sv */
`timescale 1ns / 1ps

package vma_pkg;

	localparam int DATA_W            = 32;
	localparam int WINDOW_LENGTH_DEF = 8;

	// Widest dividend: a 33-bit position difference times 1000 needs 43 bits.
	localparam int DVD_W  = 43;
	localparam int DVR_W  = 32;
	localparam int STEP_W = $clog2(DVD_W + 1);

	localparam logic signed [DVD_W-1:0] MS_PER_SECOND = DVD_W'(1000);

	typedef struct packed {
		logic        [DATA_W-1:0] time_ms;
		logic signed [DATA_W-1:0] position;
	} sample_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] velocity;
		logic                     velocity_valid;
	} result_t;

	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
		logic [DVD_W-1:0]  dividend;
		logic [DVR_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL,
		ST_DIV1_GO,
		ST_DIV1_WAIT,
		ST_SAT,
		ST_ACC,
		ST_DIV2_GO,
		ST_DIV2_WAIT,
		ST_FIN,
		ST_EMIT
	} state_t;

endpackage

/* design/vma_ram.sv */
`timescale 1ns / 1ps

module vma_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 8,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* design/vma_div.sv */
`timescale 1ns / 1ps

module vma_div
	import vma_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DVR_W:0]    rem_q;
	logic [DVD_W-1:0]  quo_q;
	logic [DVR_W-1:0]  dvr_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [DVR_W:0] rem_shift;
	logic           ge;
	logic [DVR_W:0] rem_next;

	// Restoring division, one quotient bit per cycle. The dividend is loaded
	// left aligned so that only the requested number of steps is run.
	always_comb begin
		rem_shift = {rem_q[DVR_W-1:0], quo_q[DVD_W-1]};
		ge        = rem_shift >= {1'b0, dvr_q};
		rem_next  = ge ? (rem_shift - {1'b0, dvr_q}) : rem_shift;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

/* design/velocity_moving_average.sv */
`timescale 1ns / 1ps

// Velocity estimator with a moving average over timestamped position samples.
// The sample channel carries a millisecond timestamp and a signed Q15.16
// position; a sample transfers when sample_valid is high and sample_stall low.
// Every sample yields exactly one transfer on the result channel, carrying the
// averaged velocity and a flag that tells whether a velocity was computed.
// A velocity sample spends almost all of its time in the shared serial
// divider: 43 steps for the slope and 32 + clog2(WINDOW_LENGTH) steps for the
// average. Samples with a zero timestamp, or that give no velocity, skip the
// divider and pass from ST_PREP straight to ST_EMIT. The next sample can
// transfer once a result is registered and the block is back in ST_IDLE.
// One sample is in work at a time and sample_stall stays high until its result
// sits in the output register. When result_stall holds that register, the
// block finishes the next sample and then waits to hand it on.
// Reset forgets the previous sample and empties the velocity window; the
// window memory itself is not cleared, since entries are only read once the
// window has been filled.
module velocity_moving_average
	import vma_pkg::*;
#(
	parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    sample_valid,
	output logic    sample_stall,
	input  sample_t sample,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam int SUM_W  = DATA_W + $clog2(WINDOW_LENGTH);
	localparam int FILL_W = $clog2(WINDOW_LENGTH + 1);
	localparam int SLOT_W = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;

	localparam logic [DVD_W-1:0] MAG_POS_MAX = DVD_W'(64'h7FFF_FFFF);
	localparam logic [DVD_W-1:0] MAG_NEG_MAX = DVD_W'(64'h8000_0000);

	state_t state_q, state_d;

	sample_t                  smp_q;
	logic signed [DATA_W-1:0] prev_pos_q;
	logic        [DATA_W-1:0] prev_time_q;
	logic                     have_prev_q;
	logic        [FILL_W-1:0] fill_q;
	logic        [SLOT_W-1:0] slot_q;
	logic signed [SUM_W-1:0]  sum_q;

	logic signed [DATA_W:0]   dp_q;
	logic        [DATA_W-1:0] dt_q;
	logic signed [DVD_W-1:0]  prod_q;
	logic signed [DATA_W-1:0] inst_q;
	logic                     neg_q;
	logic signed [DATA_W-1:0] vel_q;
	logic                     vld_q;

	result_t res_q;
	logic    res_valid_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic [DATA_W-1:0] old_vel;
	logic              win_full;
	logic              res_free;
	logic              do_velocity;
	logic [DVD_W-1:0]  prod_mag;
	logic [SUM_W-1:0]  sum_mag;
	logic [DATA_W-1:0] inst_d;
	logic [DATA_W-1:0] qlow;

	vma_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	vma_ram #(
		.WIDTH (DATA_W),
		.DEPTH (WINDOW_LENGTH)
	) u_window (
		.clk   (clk),
		.we    (state_q == ST_ACC),
		.waddr (slot_q),
		.wdata (inst_q),
		.raddr (slot_q),
		.rdata (old_vel)
	);

	always_comb begin
		win_full    = fill_q == FILL_W'(WINDOW_LENGTH);
		res_free    = !res_valid_q || !result_stall;
		do_velocity = have_prev_q && (smp_q.time_ms > prev_time_q);
		prod_mag    = prod_q[DVD_W-1] ? DVD_W'(-prod_q) : DVD_W'(prod_q);
		sum_mag     = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
		qlow        = div_rsp.quotient[DATA_W-1:0];

		// Saturate the slope magnitude back to a signed 32-bit velocity.
		if (neg_q) begin
			inst_d = (div_rsp.quotient > MAG_NEG_MAX) ? 32'h8000_0000 : (~qlow + 32'd1);
		end else begin
			inst_d = (div_rsp.quotient > MAG_POS_MAX) ? 32'h7FFF_FFFF : qlow;
		end
	end

	always_comb begin
		div_req.start    = 1'b0;
		div_req.steps    = STEP_W'(DVD_W);
		div_req.dividend = prod_mag;
		div_req.divisor  = dt_q;
		if (state_q == ST_DIV1_GO) begin
			div_req.start = 1'b1;
		end else if (state_q == ST_DIV2_GO) begin
			div_req.start    = 1'b1;
			div_req.steps    = STEP_W'(SUM_W);
			div_req.dividend = {sum_mag, {(DVD_W - SUM_W){1'b0}}};
			div_req.divisor  = DVR_W'(fill_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		sample_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				sample_stall = 1'b0;
				if (sample_valid) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				if (smp_q.time_ms != '0 && do_velocity) begin
					state_d = ST_MUL;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_MUL:       state_d = ST_DIV1_GO;
			ST_DIV1_GO:   state_d = ST_DIV1_WAIT;
			ST_DIV1_WAIT: if (div_rsp.done) state_d = ST_SAT;
			ST_SAT:       state_d = ST_ACC;
			ST_ACC:       state_d = ST_DIV2_GO;
			ST_DIV2_GO:   state_d = ST_DIV2_WAIT;
			ST_DIV2_WAIT: if (div_rsp.done) state_d = ST_FIN;
			ST_FIN:       state_d = ST_EMIT;
			ST_EMIT:      if (res_free) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// Estimator state: previous sample and window bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_pos_q  <= '0;
			prev_time_q <= '0;
			have_prev_q <= 1'b0;
			fill_q      <= '0;
			slot_q      <= '0;
			sum_q       <= '0;
		end else begin
			if (state_q == ST_PREP && smp_q.time_ms != '0) begin
				prev_pos_q  <= smp_q.position;
				prev_time_q <= smp_q.time_ms;
				have_prev_q <= 1'b1;
			end
			// The entry being overwritten leaves the sum once the window is full.
			if (state_q == ST_DIV1_GO && win_full) begin
				sum_q <= sum_q - SUM_W'($signed(old_vel));
			end
			if (state_q == ST_ACC) begin
				sum_q  <= sum_q + SUM_W'(inst_q);
				slot_q <= (slot_q == SLOT_W'(WINDOW_LENGTH - 1)) ? '0 : slot_q + SLOT_W'(1);
				if (!win_full) begin
					fill_q <= fill_q + FILL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (sample_valid) begin
					smp_q <= sample;
				end
			end
			ST_PREP: begin
				dp_q  <= $signed({smp_q.position[DATA_W-1], smp_q.position})
				       - $signed({prev_pos_q[DATA_W-1], prev_pos_q});
				dt_q  <= smp_q.time_ms - prev_time_q;
				vel_q <= '0;
				vld_q <= 1'b0;
			end
			ST_MUL: begin
				prod_q <= DVD_W'($signed(dp_q)) * MS_PER_SECOND;
			end
			ST_DIV1_GO: begin
				neg_q <= prod_q[DVD_W-1];
			end
			ST_SAT: begin
				inst_q <= inst_d;
			end
			ST_DIV2_GO: begin
				neg_q <= sum_q[SUM_W-1];
			end
			ST_FIN: begin
				vel_q <= neg_q ? (~qlow + 32'd1) : qlow;
				vld_q <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Output register: holds a result until its transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && res_free) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && res_free) begin
			res_q.velocity       <= vel_q;
			res_q.velocity_valid <= vld_q;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule
